FILE: rtl/tret_pkg.sv
// shared types and constants of the touch region event tracker
package tret_pkg;

    // field widths
    localparam int XY_W   = 13;
    localparam int ID_W   = 5;
    localparam int DIM_W  = 12;
    localparam int CMD_W  = 2;
    localparam int EV_W   = 3;
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELLIPSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONSUME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI   = 3'd5;

    // input commands
    localparam logic [CMD_W-1:0] CMD_DOWN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UP     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd3;

    // result events
    localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EV_W-1:0] EV_ENTER  = 3'd1;
    localparam logic [EV_W-1:0] EV_LEAVE  = 3'd2;
    localparam logic [EV_W-1:0] EV_DOWN   = 3'd3;
    localparam logic [EV_W-1:0] EV_UP     = 3'd4;
    localparam logic [EV_W-1:0] EV_MOVE   = 3'd5;
    localparam logic [EV_W-1:0] EV_CANCEL = 3'd6;

    // hit test request and response
    typedef struct packed {
        logic start;
        logic ellipse;
    } hit_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } hit_rsp_t;

endpackage

FILE: rtl/tret_hit_unit.sv
// region hit test: direct rectangle compare, ellipse through one shared multiplier
module tret_hit_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tret_pkg::hit_req_t                     req,
    input  logic signed [tret_pkg::XY_W-1:0]       pos_x,
    input  logic signed [tret_pkg::XY_W-1:0]       pos_y,
    input  logic        [tret_pkg::DIM_W-1:0]      width,
    input  logic        [tret_pkg::DIM_W-1:0]      height,
    output tret_pkg::hit_rsp_t                     rsp
);
    import tret_pkg::*;

    localparam logic [2:0] STEP_AH  = 3'd0;
    localparam logic [2:0] STEP_BW  = 3'd1;
    localparam logic [2:0] STEP_WH  = 3'd2;
    localparam logic [2:0] STEP_AA  = 3'd3;
    localparam logic [2:0] STEP_BB  = 3'd4;
    localparam logic [2:0] STEP_CC  = 3'd5;
    localparam logic [2:0] STEP_CMP = 3'd6;

    logic                busy_reg;
    logic [2:0]          step_reg;
    logic                done_reg;
    logic                inside_reg;
    logic [XY_W-1:0]     ax_reg, ay_reg;
    logic [DIM_W-1:0]    w_reg, h_reg;
    logic [MUL_W-1:0]    a_reg, b_reg, c_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W:0]     acc_reg;

    logic [XY_W-1:0]     abs_x, abs_y;
    logic                dims_ok;
    logic signed [XY_W+1:0] x2, y2, w_s, h_s;
    logic                rect_hit;
    logic [MUL_W-1:0]    op_a, op_b;
    logic                ellipse_hit;

    // magnitudes; the most negative value maps to its unsigned magnitude
    assign abs_x = pos_x[XY_W-1] ? (~pos_x + 1'b1) : pos_x;
    assign abs_y = pos_y[XY_W-1] ? (~pos_y + 1'b1) : pos_y;

    // rectangle test: -w <= 2x < w and -h <= 2y < h
    assign dims_ok  = (width != '0) && (height != '0);
    assign x2       = {pos_x[XY_W-1], pos_x, 1'b0};
    assign y2       = {pos_y[XY_W-1], pos_y, 1'b0};
    assign w_s      = $signed({3'b000, width});
    assign h_s      = $signed({3'b000, height});
    assign rect_hit = dims_ok && (x2 >= -w_s) && (x2 < w_s) && (y2 >= -h_s) && (y2 < h_s);

    // operand select for the shared multiplier
    always_comb begin
        case (step_reg)
            STEP_AH: begin
                op_a = {{(MUL_W-XY_W){1'b0}}, ax_reg};
                op_b = {{(MUL_W-DIM_W){1'b0}}, h_reg};
            end
            STEP_BW: begin
                op_a = {{(MUL_W-XY_W){1'b0}}, ay_reg};
                op_b = {{(MUL_W-DIM_W){1'b0}}, w_reg};
            end
            STEP_WH: begin
                op_a = {{(MUL_W-DIM_W){1'b0}}, w_reg};
                op_b = {{(MUL_W-DIM_W){1'b0}}, h_reg};
            end
            STEP_AA: begin
                op_a = a_reg;
                op_b = a_reg;
            end
            STEP_BB: begin
                op_a = b_reg;
                op_b = b_reg;
            end
            STEP_CC: begin
                op_a = c_reg;
                op_b = c_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // 4(A^2 + B^2) <= C^2 with A = |x|h, B = |y|w, C = wh
    assign ellipse_hit = {acc_reg, 2'b00} <= {3'b000, prod_reg};

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_AH;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (req.ellipse && dims_ok) begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_AH;
                end else begin
                    done_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (step_reg == STEP_CMP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= {{MUL_W{1'b0}}, op_a} * {{MUL_W{1'b0}}, op_b};
        if (req.start) begin
            ax_reg     <= abs_x;
            ay_reg     <= abs_y;
            w_reg      <= width;
            h_reg      <= height;
            inside_reg <= rect_hit;
        end else if (busy_reg) begin
            case (step_reg)
                STEP_BW:  a_reg <= prod_reg[MUL_W-1:0];
                STEP_WH:  b_reg <= prod_reg[MUL_W-1:0];
                STEP_AA:  c_reg <= prod_reg[MUL_W-1:0];
                STEP_BB:  acc_reg <= {1'b0, prod_reg};
                STEP_CC:  acc_reg <= acc_reg + {1'b0, prod_reg};
                STEP_CMP: inside_reg <= ellipse_hit;
                default: ;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = inside_reg;

endmodule

FILE: rtl/touch_region_event_tracker_core.sv
// top level: touch region event tracker with capture state and result output register
// the rectangle test is decided directly; the ellipse test runs six products through one
// shared 24x24 multiplier; a new input is taken only once the last result of the previous
// input is loaded into the output register, so output stalls also hold the input;
// a second result of the same input is loaded into the output register as the first is taken
// reset: aresetn synchronous active low; clears captured flags, active touch, configuration registers and output valid
module touch_region_event_tracker_core #(
    parameter int MAX_TOUCHES = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [tret_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tret_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [31:0]                          s_axis_tdata,  // pos_x, pos_y, touch_id
    input  logic [1:0]                           s_axis_tuser,  // command
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [31:0]                          m_axis_tdata,  // out_x, out_y, out_id, consumed
    output logic [2:0]                           m_axis_tuser,  // event_res
    output logic                                 m_axis_tlast
);
    import tret_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT2  = 2'd3;

    // configuration registers
    logic [DIM_W-1:0] width_reg, height_reg;
    logic             ellipse_reg, consume_reg, dynamic_reg, multi_reg;

    // tracking state
    logic [MAX_TOUCHES-1:0] flags_reg, flags_next;
    logic                   active_valid_reg, active_valid_next;
    logic [ID_W-1:0]        owner_id_reg, owner_id_next;

    // sequencer and held input item
    logic [1:0]             state_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [XY_W-1:0]        x_reg, y_reg;
    logic [ID_W-1:0]        id_reg;
    logic                   cons_reg;
    logic [EV_W-1:0]        ev1_reg;

    // output register
    logic                   m_valid_reg;
    logic [EV_W-1:0]        m_ev_reg;
    logic [XY_W-1:0]        m_x_reg, m_y_reg;
    logic [ID_W-1:0]        m_id_reg;
    logic                   m_cons_reg, m_last_reg;

    logic                   s_accept;
    logic                   out_free;
    hit_req_t               hit_req;
    hit_rsp_t               hit_rsp;

    // decision signals
    logic                   in_region;
    logic                   flag_cur, in_range, is_active, flag_after;
    logic                   flag_wr, flag_val, clr_all;
    logic [EV_W-1:0]        ev0, ev1;
    logic                   have_ev, two_ev, cons;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // hit test unit, started on every accepted transaction
    assign hit_req.start   = s_accept;
    assign hit_req.ellipse = ellipse_reg;

    tret_hit_unit u_hit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hit_req),
        .pos_x   (s_axis_tdata[XY_W-1:0]),
        .pos_y   (s_axis_tdata[2*XY_W-1:XY_W]),
        .width   (width_reg),
        .height  (height_reg),
        .rsp     (hit_rsp)
    );

    assign in_region = hit_rsp.hit;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= '0;
            height_reg  <= '0;
            ellipse_reg <= 1'b0;
            consume_reg <= 1'b1;
            dynamic_reg <= 1'b0;
            multi_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:   width_reg   <= cfg_data;
                REG_HEIGHT:  height_reg  <= cfg_data;
                REG_ELLIPSE: ellipse_reg <= cfg_data[0];
                REG_CONSUME: consume_reg <= cfg_data[0];
                REG_DYNAMIC: dynamic_reg <= cfg_data[0];
                REG_MULTI:   multi_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // flag lookup for the current id; ids past the table read as not captured
    always_comb begin
        flag_cur = 1'b0;
        in_range = 1'b0;
        for (int i = 0; i < MAX_TOUCHES; i++) begin
            if (32'(id_reg) == 32'(i)) begin
                flag_cur = flags_reg[i];
                in_range = 1'b1;
            end
        end
    end

    assign is_active = active_valid_reg && (owner_id_reg == id_reg);

    // event decision per command
    always_comb begin
        flag_wr           = 1'b0;
        flag_val          = 1'b0;
        clr_all           = 1'b0;
        active_valid_next = active_valid_reg;
        owner_id_next     = owner_id_reg;
        ev0               = EV_NONE;
        ev1               = EV_NONE;
        have_ev           = 1'b0;
        two_ev            = 1'b0;
        cons              = 1'b0;
        flag_after        = flag_cur;
        case (cmd_reg)
            CMD_DOWN: begin
                if (in_region) begin
                    flag_wr  = 1'b1;
                    flag_val = 1'b1;
                    if (!active_valid_reg || multi_reg) begin
                        active_valid_next = 1'b1;
                        owner_id_next     = id_reg;
                        ev0               = EV_DOWN;
                        have_ev           = 1'b1;
                    end
                    cons = consume_reg;
                end
            end
            CMD_MOVE: begin
                if (dynamic_reg) begin
                    if (in_region) begin
                        flag_wr    = 1'b1;
                        flag_val   = 1'b1;
                        flag_after = in_range;
                        if (!active_valid_reg || multi_reg) begin
                            active_valid_next = 1'b1;
                            owner_id_next     = id_reg;
                            ev0               = EV_ENTER;
                            have_ev           = 1'b1;
                        end
                    end else if (flag_cur) begin
                        flag_wr    = 1'b1;
                        flag_after = 1'b0;
                        if (is_active || multi_reg) begin
                            ev0               = EV_LEAVE;
                            have_ev           = 1'b1;
                            active_valid_next = 1'b0;
                        end
                    end
                end
                // move follows on the state left by enter or leave
                if (flag_after) begin
                    if ((active_valid_next && (owner_id_next == id_reg)) || multi_reg) begin
                        if (have_ev) begin
                            ev1    = EV_MOVE;
                            two_ev = 1'b1;
                        end else begin
                            ev0     = EV_MOVE;
                            have_ev = 1'b1;
                        end
                    end
                    cons = consume_reg;
                end
            end
            CMD_UP: begin
                if (flag_cur) begin
                    flag_wr = 1'b1;
                    if (is_active || multi_reg) begin
                        ev0               = EV_UP;
                        have_ev           = 1'b1;
                        active_valid_next = 1'b0;
                    end
                    cons = consume_reg;
                end
            end
            default: begin
                // cancel: drop every capture
                clr_all           = 1'b1;
                active_valid_next = 1'b0;
                owner_id_next     = '0;
                ev0               = (active_valid_reg || multi_reg) ? EV_CANCEL : EV_NONE;
            end
        endcase
    end

    // next captured flags
    always_comb begin
        flags_next = flags_reg;
        if (clr_all) begin
            flags_next = '0;
        end else if (flag_wr) begin
            for (int i = 0; i < MAX_TOUCHES; i++) begin
                if (32'(id_reg) == 32'(i)) begin
                    flags_next[i] = flag_val;
                end
            end
        end
    end

    // sequencer and tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            flags_reg        <= '0;
            active_valid_reg <= 1'b0;
            owner_id_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (hit_rsp.done) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        flags_reg        <= flags_next;
                        active_valid_reg <= active_valid_next;
                        owner_id_reg     <= owner_id_next;
                        state_reg        <= two_ev ? ST_EMIT2 : ST_IDLE;
                    end
                end
                ST_EMIT2: begin
                    if (m_axis_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output valid: set when a result is loaded, cleared once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DECIDE && out_free) ||
                     (state_reg == ST_EMIT2 && m_axis_tready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // input item and output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_axis_tuser;
            x_reg   <= s_axis_tdata[XY_W-1:0];
            y_reg   <= s_axis_tdata[2*XY_W-1:XY_W];
            id_reg  <= s_axis_tdata[2*XY_W+ID_W-1:2*XY_W];
        end
        if (state_reg == ST_DECIDE && out_free) begin
            ev1_reg    <= ev1;
            cons_reg   <= cons;
            m_ev_reg   <= ev0;
            m_cons_reg <= cons;
            m_last_reg <= !two_ev;
            if (have_ev && cmd_reg != CMD_CANCEL) begin
                m_x_reg  <= x_reg;
                m_y_reg  <= y_reg;
                m_id_reg <= id_reg;
            end else begin
                m_x_reg  <= '0;
                m_y_reg  <= '0;
                m_id_reg <= '0;
            end
        end else if (state_reg == ST_EMIT2 && m_axis_tready) begin
            m_ev_reg   <= ev1_reg;
            m_cons_reg <= cons_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_ev_reg;
    assign m_axis_tdata  = {m_cons_reg, m_id_reg, m_y_reg, m_x_reg};
    assign m_axis_tlast  = m_last_reg;

    // a pending second result means the first one sits in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT2) |-> m_valid_reg)
        else $error("second result pending without first result in output register");

    // the hit unit only answers for an item in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        hit_rsp.done |-> (state_reg == ST_WAIT))
        else $error("hit test finished outside of wait state");

    // a cancel leaves no capture behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && out_free && cmd_reg == CMD_CANCEL)
        |=> (flags_reg == '0 && !active_valid_reg))
        else $error("cancel did not clear capture state");

    // only a move can produce two results, and the first is then not last
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT2) |-> (cmd_reg == CMD_MOVE && !m_last_reg))
        else $error("two results from a command other than move");

endmodule

FILE: dv/tb_touch_region_event_tracker_core.sv
// self-checking testbench of the touch region event tracker core
module tb_touch_region_event_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tret_pkg::*;

    localparam int NUM_IDS     = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 16;
    localparam int HOLD_CYC    = 300;

    // one predicted touch event
    typedef struct {
        logic [EV_W-1:0]   ev;
        logic [XY_W-1:0]   x;
        logic [XY_W-1:0]   y;
        logic [ID_W-1:0]   id;
        logic              consumed;
        logic              last;
    } touch_event_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_axis_tready;
    logic [31:0]           s_data;
    logic [1:0]            s_user;
    logic                  m_axis_tvalid;
    logic                  m_ready;
    logic [31:0]           m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    // predictor copy of the registers and the capture state
    logic [DIM_W-1:0]      cfg_w;
    logic [DIM_W-1:0]      cfg_h;
    bit                    cfg_ellipse;
    bit                    cfg_consume;
    bit                    cfg_dynamic;
    bit                    cfg_multi;
    bit [NUM_IDS-1:0]      touch_captured;
    bit                    active_vld;
    logic [ID_W-1:0]       owner_id;

    touch_event_t          pending_events[$];
    int                    err_count;
    int                    cycle_count;
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    bit                    hold_rx;

    touch_region_event_tracker_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < 60)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        err_count++;
    endtask

    // hit test against the centered region
    function automatic bit region_hit(logic signed [XY_W-1:0] px, logic signed [XY_W-1:0] py);
        longint sx, sy, w, h;
        longint unsigned ax, ay, uw, uh, lhs, rhs;
        w = longint'(cfg_w);
        h = longint'(cfg_h);
        if (w == 0 || h == 0)
            return 1'b0;
        sx = px;
        sy = py;
        if (cfg_ellipse) begin
            ax  = (sx < 0) ? -sx : sx;
            ay  = (sy < 0) ? -sy : sy;
            uw  = w;
            uh  = h;
            lhs = 4 * ax * ax * uh * uh + 4 * ay * ay * uw * uw;
            rhs = uw * uw * uh * uh;
            return lhs <= rhs;
        end
        return (2 * sx >= -w) && (2 * sx < w) && (2 * sy >= -h) && (2 * sy < h);
    endfunction

    function automatic bit owns_event(logic [ID_W-1:0] id);
        return (active_vld && owner_id == id) || cfg_multi;
    endfunction

    // work out the events one accepted command causes
    task automatic predict_events(input logic [CMD_W-1:0] cmd, input logic [XY_W-1:0] px,
                                  input logic [XY_W-1:0] py, input logic [ID_W-1:0] id);
        logic [EV_W-1:0] evs[2];
        int              n;
        bit              cons;
        bit              hit;
        touch_event_t    e;
        n    = 0;
        cons = 1'b0;
        hit  = region_hit(px, py);
        case (cmd)
            CMD_DOWN: begin
                if (hit) begin
                    touch_captured[id] = 1'b1;
                    if (!active_vld || cfg_multi) begin
                        active_vld = 1'b1;
                        owner_id   = id;
                        evs[n++]   = EV_DOWN;
                    end
                    cons = cfg_consume;
                end
            end
            CMD_MOVE: begin
                if (cfg_dynamic) begin
                    if (hit) begin
                        touch_captured[id] = 1'b1;
                        if (!active_vld || cfg_multi) begin
                            active_vld = 1'b1;
                            owner_id   = id;
                            evs[n++]   = EV_ENTER;
                        end
                    end else if (touch_captured[id]) begin
                        touch_captured[id] = 1'b0;
                        if (owns_event(id)) begin
                            evs[n++]   = EV_LEAVE;
                            active_vld = 1'b0;
                        end
                    end
                end
                if (touch_captured[id]) begin
                    if (owns_event(id))
                        evs[n++] = EV_MOVE;
                    cons = cfg_consume;
                end
            end
            CMD_UP: begin
                if (touch_captured[id]) begin
                    touch_captured[id] = 1'b0;
                    if (owns_event(id)) begin
                        evs[n++]   = EV_UP;
                        active_vld = 1'b0;
                    end
                    cons = cfg_consume;
                end
            end
            default: begin
                // cancel carries no position and clears every capture
                e.ev = (active_vld || cfg_multi) ? EV_CANCEL : EV_NONE;
                e.x = '0; e.y = '0; e.id = '0; e.consumed = 1'b0; e.last = 1'b1;
                touch_captured = '0;
                active_vld     = 1'b0;
                owner_id       = '0;
                pending_events.push_back(e);
                return;
            end
        endcase
        if (n == 0) begin
            e.ev = EV_NONE; e.x = '0; e.y = '0; e.id = '0;
            e.consumed = cons; e.last = 1'b1;
            pending_events.push_back(e);
        end else begin
            for (int k = 0; k < n; k++) begin
                e.ev = evs[k]; e.x = px; e.y = py; e.id = id;
                e.consumed = cons; e.last = (k == n - 1);
                pending_events.push_back(e);
            end
        end
    endtask

    // input transactions feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_axis_tready)
            predict_events(s_user, s_data[12:0], s_data[25:13], s_data[30:26]);
    end

    // result transactions against the oldest prediction
    always @(posedge aclk) begin
        touch_event_t e;
        if (aresetn && m_axis_tvalid && m_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                e = pending_events.pop_front();
                if (m_axis_tuser != e.ev)
                    report_mismatch("event_res", m_axis_tuser, e.ev);
                if (m_axis_tdata[12:0] != e.x)
                    report_mismatch("out_x", m_axis_tdata[12:0], e.x);
                if (m_axis_tdata[25:13] != e.y)
                    report_mismatch("out_y", m_axis_tdata[25:13], e.y);
                if (m_axis_tdata[30:26] != e.id)
                    report_mismatch("out_id", m_axis_tdata[30:26], e.id);
                if (m_axis_tdata[31] != e.consumed)
                    report_mismatch("consumed", m_axis_tdata[31], e.consumed);
                if (m_axis_tlast != e.last)
                    report_mismatch("last", m_axis_tlast, e.last);
            end
        end
    end

    // result side ready with random stalls and the long hold-off
    always @(negedge aclk) begin
        if (hold_rx)
            m_ready <= 1'b0;
        else if (!rx_idle_on)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= 14);
    end

    // one command transaction, valid stays high until the next call decides
    task automatic send_touch(input logic [CMD_W-1:0] cmd, input logic [XY_W-1:0] px,
                              input logic [XY_W-1:0] py, input logic [ID_W-1:0] id);
        int gap;
        gap = (tx_idle_on && $urandom_range(99) < 14) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {1'b0, id, py, px};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // drop valid and let every outstanding result come out
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // write all six registers, predictor follows at the write edge
    task automatic apply_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input bit ell, input bit cons, input bit dyn, input bit multi);
        logic [CFG_IDX_W-1:0]  idx[6];
        logic [CFG_DATA_W-1:0] val[6];
        idx[0] = REG_WIDTH;   val[0] = w;
        idx[1] = REG_HEIGHT;  val[1] = h;
        idx[2] = REG_ELLIPSE; val[2] = CFG_DATA_W'(ell);
        idx[3] = REG_CONSUME; val[3] = CFG_DATA_W'(cons);
        idx[4] = REG_DYNAMIC; val[4] = CFG_DATA_W'(dyn);
        idx[5] = REG_MULTI;   val[5] = CFG_DATA_W'(multi);
        for (int i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            case (idx[i])
                REG_WIDTH:   cfg_w       = val[i];
                REG_HEIGHT:  cfg_h       = val[i];
                REG_ELLIPSE: cfg_ellipse = val[i][0];
                REG_CONSUME: cfg_consume = val[i][0];
                REG_DYNAMIC: cfg_dynamic = val[i][0];
                REG_MULTI:   cfg_multi   = val[i][0];
                default: ;
            endcase
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // coordinate mostly near the region border, sometimes anywhere
    function automatic logic [XY_W-1:0] pick_coord(int dim);
        int lim, v;
        lim = dim / 2 + 6;
        if ($urandom_range(99) < 80)
            v = int'($urandom_range(2 * lim)) - lim;
        else
            v = int'($urandom_range(8191)) - 4096;
        if (v > 4095)  v = 4095;
        if (v < -4096) v = -4096;
        return v[XY_W-1:0];
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        return ($urandom_range(99) < 75) ? ID_W'($urandom_range(3)) : ID_W'($urandom_range(31));
    endfunction

    // down, a few moves, then up, cancel or nothing; some noise between
    task automatic send_gesture(inout int sent);
        logic [ID_W-1:0] id;
        int              moves;
        int              ending;
        if ($urandom_range(99) < 15) begin
            send_touch(CMD_W'($urandom_range(3)), XY_W'($urandom), XY_W'($urandom),
                       ID_W'($urandom));
            sent++;
            return;
        end
        id = pick_id();
        send_touch(CMD_DOWN, pick_coord(cfg_w), pick_coord(cfg_h), id);
        sent++;
        moves = $urandom_range(5);
        repeat (moves) begin
            send_touch(CMD_MOVE, pick_coord(cfg_w), pick_coord(cfg_h), id);
            sent++;
        end
        ending = $urandom_range(99);
        if (ending < 80) begin
            send_touch(CMD_UP, pick_coord(cfg_w), pick_coord(cfg_h), id);
            sent++;
        end else if (ending < 90) begin
            send_touch(CMD_CANCEL, XY_W'($urandom), XY_W'($urandom), ID_W'($urandom));
            sent++;
        end
    endtask

    // registers at their reset values: zero size, nothing ever hits
    task automatic test_reset_values();
        send_touch(CMD_DOWN, '0, '0, 5'd0);
        send_touch(CMD_MOVE, '0, '0, 5'd0);
        send_touch(CMD_CANCEL, '0, '0, 5'd0);
        wait_idle();
    endtask

    // directed corners of the rectangle and ellipse tests and of the event rules
    task automatic test_directed();
        // rectangle 200 x 100, single touch, static
        apply_config(12'd200, 12'd100, 1'b0, 1'b1, 1'b0, 1'b0);
        send_touch(CMD_DOWN, -13'sd100, -13'sd50, 5'd3);
        send_touch(CMD_MOVE, 13'sd99, 13'sd49, 5'd3);
        send_touch(CMD_DOWN, 13'sd0, 13'sd0, 5'd7);
        send_touch(CMD_MOVE, 13'sd4095, -13'sd4096, 5'd7);
        send_touch(CMD_UP, 13'sd0, 13'sd0, 5'd7);
        send_touch(CMD_UP, 13'sd100, 13'sd0, 5'd3);
        send_touch(CMD_DOWN, 13'sd100, 13'sd0, 5'd4);
        send_touch(CMD_CANCEL, 13'sd0, 13'sd0, 5'd0);
        send_touch(CMD_DOWN, 13'sd0, 13'sd0, 5'd31);
        send_touch(CMD_CANCEL, -13'sd4096, 13'sd4095, 5'd31);
        wait_idle();
        // largest ellipse, dynamic and multi-touch: enter, repeated enter, leave, up
        apply_config(12'd4095, 12'd4095, 1'b1, 1'b0, 1'b1, 1'b1);
        send_touch(CMD_MOVE, 13'sd2047, 13'sd0, 5'd1);
        send_touch(CMD_MOVE, 13'sd0, 13'sd2047, 5'd1);
        send_touch(CMD_DOWN, -13'sd2047, 13'sd0, 5'd2);
        send_touch(CMD_MOVE, 13'sd2048, 13'sd0, 5'd1);
        send_touch(CMD_MOVE, 13'sd0, 13'sd0, 5'd2);
        send_touch(CMD_UP, 13'sd0, 13'sd0, 5'd5);
        send_touch(CMD_DOWN, 13'sd0, 13'sd0, 5'd6);
        send_touch(CMD_UP, 13'sd0, 13'sd0, 5'd2);
        send_touch(CMD_CANCEL, 13'sd0, 13'sd0, 5'd0);
        send_touch(CMD_MOVE, -13'sd4096, -13'sd4096, 5'd0);
        wait_idle();
        // zero height counts as outside
        apply_config(12'd4095, 12'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        send_touch(CMD_DOWN, 13'sd0, 13'sd0, 5'd0);
        send_touch(CMD_MOVE, 13'sd0, 13'sd0, 5'd0);
        send_touch(CMD_CANCEL, 13'sd0, 13'sd0, 5'd0);
        wait_idle();
    endtask

    // random gestures over a series of register settings
    task automatic test_random_phases();
        int sent;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_config(12'd0, 12'd300, 1'b0, 1'b1, 1'b1, 1'b1);
                1: apply_config(12'd4095, 12'd4095, 1'b0, 1'b1, 1'b0, 1'b0);
                2: apply_config(12'd1, 12'd1, 1'b1, 1'b0, 1'b1, 1'b0);
                3: apply_config(12'd300, 12'd150, 1'b1, 1'b1, 1'b1, 1'b1);
                4: apply_config(12'd4095, 12'd1, 1'b1, 1'b1, 1'b1, 1'b0);
                5: apply_config(12'd64, 12'd4000, 1'b0, 1'b0, 1'b1, 1'b1);
                default: apply_config(DIM_W'($urandom_range(4095)), DIM_W'($urandom_range(4095)),
                                      1'($urandom_range(1)), 1'($urandom_range(1)),
                                      1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            // one phase runs without any idling on either side
            tx_idle_on = (p != 3);
            rx_idle_on = (p != 3);
            sent = 0;
            while (sent < 140)
                send_gesture(sent);
            wait_idle();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering random gestures, whose moves can give two results
    task automatic test_backpressure();
        int sent;
        apply_config(12'd400, 12'd400, 1'b0, 1'b1, 1'b1, 1'b1);
        fork
            begin
                hold_rx = 1'b1;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_rx = 1'b0;
            end
        join_none
        sent = 0;
        while (sent < 40)
            send_gesture(sent);
        wait_idle();
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        s_user      = '0;
        m_ready     = 1'b0;
        err_count   = 0;
        cycle_count = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        hold_rx     = 1'b0;
        // predictor starts at the reset state
        cfg_w          = '0;
        cfg_h          = '0;
        cfg_ellipse    = 1'b0;
        cfg_consume    = 1'b1;
        cfg_dynamic    = 1'b0;
        cfg_multi      = 1'b0;
        touch_captured = '0;
        active_vld     = 1'b0;
        owner_id       = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_directed();
        test_random_phases();
        test_backpressure();

        wait_idle();
        if (err_count == 0 && pending_events.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
